// File: hdl/tgc_pkg.sv
// Package for the touch gesture classifier: field widths, codes, zone constants
// and the display-dimension helpers shared by the interfaces and the modules.
// Depends on nothing.
package tgc_pkg;

    // Fixed widths of the payload and configuration fields.
    localparam int RAW_BITS   = 12;
    localparam int DIM_BITS   = 13;
    localparam int ROT_BITS   = 2;
    localparam int THR_BITS   = 12;
    localparam int DEB_BITS   = 24;
    localparam int FC_BITS    = 4;
    localparam int EV_BITS    = 3;
    localparam int CIDX_BITS  = 3;
    localparam int CDATA_BITS = 24;

    // Reset values of the configuration registers.
    localparam logic [DIM_BITS-1:0] RST_WIDTH    = DIM_BITS'(360);
    localparam logic [DIM_BITS-1:0] RST_HEIGHT   = DIM_BITS'(360);
    localparam logic [THR_BITS-1:0] RST_SWIPE    = THR_BITS'(80);
    localparam logic [THR_BITS-1:0] RST_TAP_MOVE = THR_BITS'(30);
    localparam logic [DEB_BITS-1:0] RST_DEBOUNCE = DEB_BITS'(250000);

    // Screen zones for tap actions.
    localparam int MUTE_ZONE_Y   = 56;
    localparam int MUTE_ZONE_W   = 104;
    localparam int BOTTOM_ZONE_H = 80;

    // Mask that picks the finger count out of the status nibble.
    localparam logic [FC_BITS-1:0] FINGER_MASK = 4'hF;

    // Reciprocal of three: floor(n * 43691 / 2^17) equals n / 3 for n below 2^17.
    localparam int unsigned THIRD_RECIP = 43691;
    localparam int          THIRD_SHIFT = 17;

    typedef enum logic [EV_BITS-1:0] {
        EV_NONE,
        EV_SWIPE_NEXT,
        EV_SWIPE_PREV,
        EV_WAKE,
        EV_VOL_DOWN,
        EV_VOL_UP,
        EV_MUTE
    } t_event;

    typedef enum logic [CIDX_BITS-1:0] {
        CFG_WIDTH,
        CFG_HEIGHT,
        CFG_ROTATION,
        CFG_SWIPE_THR,
        CFG_TAP_MOVE,
        CFG_TAP_DEBOUNCE
    } t_cfg_idx;

    typedef enum logic [ROT_BITS-1:0] {
        ROT_0,
        ROT_90,
        ROT_180,
        ROT_270
    } t_rot;

    // Display dimensions and the values derived from them at configuration time.
    typedef struct packed {
        logic [DIM_BITS-1:0] w;
        logic [DIM_BITS-1:0] h;
        logic [DIM_BITS-1:0] mx;
        logic [DIM_BITS-1:0] my;
        logic [DIM_BITS-1:0] w_third;
        logic [DIM_BITS-1:0] w_two_thirds;
    } t_dims;

    // A dimension of zero is treated as one pixel.
    function automatic logic [DIM_BITS-1:0] eff_dim(input logic [DIM_BITS-1:0] raw);
        return (raw == '0) ? DIM_BITS'(1) : raw;
    endfunction

    // Division by three through a reciprocal multiply.
    function automatic logic [DIM_BITS-1:0] third_of(input logic [DIM_BITS:0] n);
        logic [DIM_BITS+17:0] p;
        p = (DIM_BITS+18)'(n) * (DIM_BITS+18)'(THIRD_RECIP);
        return DIM_BITS'(p >> THIRD_SHIFT);
    endfunction

endpackage

// File: hdl/tgc_if.sv
// Handshake channels of the touch gesture classifier: sample in, result out,
// and the configuration write port.
// Depends on tgc_pkg.
interface tgc_sample_if import tgc_pkg::*; #(
    parameter int TIME_BITS = 48
);
    logic                 valid;
    logic                 ready;
    logic [FC_BITS-1:0]   point_count;
    logic [RAW_BITS-1:0]  raw_x;
    logic [RAW_BITS-1:0]  raw_y;
    logic [TIME_BITS-1:0] now_time;
    logic                 wake_mode;

    modport source (output valid, point_count, raw_x, raw_y, now_time, wake_mode,
                    input ready);
    modport sink   (input valid, point_count, raw_x, raw_y, now_time, wake_mode,
                    output ready);
endinterface

interface tgc_result_if import tgc_pkg::*;;
    logic               valid;
    logic               ready;
    logic [EV_BITS-1:0] gesture_event;
    logic               touch_active;

    modport source (output valid, gesture_event, touch_active, input ready);
    modport sink   (input valid, gesture_event, touch_active, output ready);
endinterface

interface tgc_cfg_if import tgc_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CIDX_BITS-1:0]  index;
    logic [CDATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/tgc_rotate.sv
// Rotates a raw panel point by the configured angle and clamps it to the display.
// Depends on tgc_pkg.
module tgc_rotate import tgc_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic [RAW_BITS-1:0]   i_raw_x,
    input  logic [RAW_BITS-1:0]   i_raw_y,
    input  t_rot                  i_rot,
    input  t_dims                 i_dims,
    output logic [COORD_BITS-1:0] o_px,
    output logic [COORD_BITS-1:0] o_py
);
    // Signed work width covers the display limits, the coordinate cap and a sign.
    localparam int SW = ((DIM_BITS > COORD_BITS) ? DIM_BITS : COORD_BITS) + 2;

    logic signed [SW-1:0] rxs, rys, smx, smy, cmask, hix, hiy, px, py, cx, cy;

    always_comb begin
        rxs   = signed'(SW'(i_raw_x));
        rys   = signed'(SW'(i_raw_y));
        smx   = signed'(SW'(i_dims.mx));
        smy   = signed'(SW'(i_dims.my));
        cmask = signed'(SW'({COORD_BITS{1'b1}}));

        // Rotate about the display corners.
        case (i_rot)
            ROT_90: begin
                px = rys;
                py = smx - rxs;
            end
            ROT_180: begin
                px = smx - rxs;
                py = smy - rys;
            end
            ROT_270: begin
                px = smy - rys;
                py = rxs;
            end
            default: begin
                px = rxs;
                py = rys;
            end
        endcase

        // Upper limits are the display edge, capped at the coordinate range.
        hix = (smx > cmask) ? cmask : smx;
        hiy = (smy > cmask) ? cmask : smy;

        cx = (px > hix) ? hix : px;
        if (cx < 0) begin
            cx = '0;
        end
        cy = (py > hiy) ? hiy : py;
        if (cy < 0) begin
            cy = '0;
        end

        o_px = cx[COORD_BITS-1:0];
        o_py = cy[COORD_BITS-1:0];
    end

endmodule

// File: hdl/tgc_release.sv
// Classifies a finished touch as a swipe, a debounced tap with its zone action,
// or nothing. Depends on tgc_pkg.
module tgc_release import tgc_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int TIME_BITS  = 48
) (
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_last_x,
    input  logic [COORD_BITS-1:0] i_last_y,
    input  logic [TIME_BITS-1:0]  i_now,
    input  logic [TIME_BITS-1:0]  i_last_tap,
    input  logic                  i_wake,
    input  t_dims                 i_dims,
    input  logic [THR_BITS-1:0]   i_swipe_thr,
    input  logic [THR_BITS-1:0]   i_tap_move,
    input  logic [DEB_BITS-1:0]   i_debounce,
    output t_event                o_event,
    output logic                  o_tap_taken
);
    localparam int MW = ((COORD_BITS + 2) > THR_BITS) ? (COORD_BITS + 2) : THR_BITS;
    localparam int ZW = ((DIM_BITS > COORD_BITS) ? DIM_BITS : COORD_BITS) + 2;

    logic signed [COORD_BITS:0] dx, dy;
    logic [MW-1:0]              ax, ay, thr, tmv;
    logic [TIME_BITS-1:0]       dt;
    logic                       swipe, tap;
    logic signed [ZW-1:0]       xs, ys, ws, hs, w3, w23;
    t_event                     zone;

    // Travel from start to last point.
    always_comb begin
        dx  = signed'({1'b0, i_last_x}) - signed'({1'b0, i_start_x});
        dy  = signed'({1'b0, i_last_y}) - signed'({1'b0, i_start_y});
        ax  = dx[COORD_BITS] ? MW'(-dx) : MW'(dx);
        ay  = dy[COORD_BITS] ? MW'(-dy) : MW'(dy);
        thr = MW'(i_swipe_thr);
        tmv = MW'(i_tap_move);
        dt  = i_now - i_last_tap;

        swipe = (ax >= thr) && (ax > (ay << 1));
        tap   = (ax <= tmv) && (ay <= tmv) && (dt >= TIME_BITS'(i_debounce));
    end

    // Zone action, chosen from the start point.
    always_comb begin
        xs  = signed'(ZW'(i_start_x));
        ys  = signed'(ZW'(i_start_y));
        ws  = signed'(ZW'(i_dims.w));
        hs  = signed'(ZW'(i_dims.h));
        w3  = signed'(ZW'(i_dims.w_third));
        w23 = signed'(ZW'(i_dims.w_two_thirds));

        if (i_wake) begin
            zone = EV_WAKE;
        end else if ((ys <= ZW'(MUTE_ZONE_Y)) && (xs >= ws - ZW'(MUTE_ZONE_W))) begin
            zone = EV_MUTE;
        end else if (ys < hs - ZW'(BOTTOM_ZONE_H)) begin
            zone = EV_NONE;
        end else if (xs < w3) begin
            zone = EV_VOL_DOWN;
        end else if (xs >= w23) begin
            zone = EV_VOL_UP;
        end else begin
            zone = EV_MUTE;
        end
    end

    // A swipe takes precedence over a tap.
    always_comb begin
        o_tap_taken = 1'b0;
        if (swipe) begin
            o_event = dx[COORD_BITS] ? EV_SWIPE_NEXT : EV_SWIPE_PREV;
        end else if (tap) begin
            o_event     = zone;
            o_tap_taken = 1'b1;
        end else begin
            o_event = EV_NONE;
        end
    end

endmodule

// File: hdl/touch_gesture_classifier.sv
// Top level of the touch gesture classifier: input register, press tracking,
// result register with skid stage, and configuration registers.
// Depends on tgc_pkg, tgc_if, tgc_rotate and tgc_release.
//
//  Port       Dir  Payload                                             Role
//  i_sample   in   point_count, raw_x, raw_y, now_time, wake_mode      poll samples
//  o_result   out  gesture_event, touch_active                         one per sample
//  i_cfg      in   index, data                                         register writes
//
// One item per cycle is sustained while results are taken; each sample passes
// through the input register, then the result register, where its result waits
// until taken. The press state is updated as each sample advances, so
// consecutive samples need no spacing.
// A skid stage behind the result register keeps the input open while a result
// waits; i_sample.ready falls only once the skid stage and the input register
// are both full.
// Reset (i_rst_n low, synchronous) clears the press state, the tap time, all
// valid flags and loads the configuration reset values. Config writes are always ready.
module touch_gesture_classifier import tgc_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int TIME_BITS  = 48
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tgc_sample_if.sink      i_sample,
    tgc_result_if.source    o_result,
    tgc_cfg_if.sink         i_cfg
);

    // Configuration registers.
    t_dims               r_dims;
    t_rot                r_rot;
    logic [THR_BITS-1:0] r_swipe_thr;
    logic [THR_BITS-1:0] r_tap_move;
    logic [DEB_BITS-1:0] r_debounce;
    logic [DIM_BITS-1:0] cfg_eff;

    assign i_cfg.ready = 1'b1;
    assign cfg_eff     = eff_dim(i_cfg.data[DIM_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims.w            <= RST_WIDTH;
            r_dims.mx           <= RST_WIDTH - DIM_BITS'(1);
            r_dims.w_third      <= third_of({1'b0, RST_WIDTH});
            r_dims.w_two_thirds <= third_of({RST_WIDTH, 1'b0});
            r_dims.h            <= RST_HEIGHT;
            r_dims.my           <= RST_HEIGHT - DIM_BITS'(1);
            r_rot               <= ROT_0;
            r_swipe_thr         <= RST_SWIPE;
            r_tap_move          <= RST_TAP_MOVE;
            r_debounce          <= RST_DEBOUNCE;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_WIDTH: begin
                    r_dims.w            <= cfg_eff;
                    r_dims.mx           <= cfg_eff - DIM_BITS'(1);
                    r_dims.w_third      <= third_of({1'b0, cfg_eff});
                    r_dims.w_two_thirds <= third_of({cfg_eff, 1'b0});
                end
                CFG_HEIGHT: begin
                    r_dims.h  <= cfg_eff;
                    r_dims.my <= cfg_eff - DIM_BITS'(1);
                end
                CFG_ROTATION:     r_rot       <= t_rot'(i_cfg.data[ROT_BITS-1:0]);
                CFG_SWIPE_THR:    r_swipe_thr <= i_cfg.data[THR_BITS-1:0];
                CFG_TAP_MOVE:     r_tap_move  <= i_cfg.data[THR_BITS-1:0];
                CFG_TAP_DEBOUNCE: r_debounce  <= i_cfg.data[DEB_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    logic                 r_in_valid;
    logic                 r_in_pressed;
    logic [RAW_BITS-1:0]  r_in_x;
    logic [RAW_BITS-1:0]  r_in_y;
    logic [TIME_BITS-1:0] r_in_now;
    logic                 r_in_wake;
    logic                 r_skid_valid;
    logic                 advance;

    assign advance        = r_in_valid && !r_skid_valid;
    assign i_sample.ready = !r_in_valid || !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
        if (i_sample.ready && i_sample.valid) begin
            r_in_pressed <= (i_sample.point_count & FINGER_MASK) != '0;
            r_in_x       <= i_sample.raw_x;
            r_in_y       <= i_sample.raw_y;
            r_in_now     <= i_sample.now_time;
            r_in_wake    <= i_sample.wake_mode;
        end
    end

    // Press tracking state.
    logic                  r_pressed;
    logic [COORD_BITS-1:0] r_start_x, r_start_y, r_last_x, r_last_y;
    logic [TIME_BITS-1:0]  r_last_tap;
    logic [COORD_BITS-1:0] px, py;
    t_event                rel_event;
    logic                  rel_tap;
    t_event                n_event;
    logic                  n_pressed;

    tgc_rotate #(
        .COORD_BITS (COORD_BITS)
    ) u_rotate (
        .i_raw_x (r_in_x),
        .i_raw_y (r_in_y),
        .i_rot   (r_rot),
        .i_dims  (r_dims),
        .o_px    (px),
        .o_py    (py)
    );

    tgc_release #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_release (
        .i_start_x   (r_start_x),
        .i_start_y   (r_start_y),
        .i_last_x    (r_last_x),
        .i_last_y    (r_last_y),
        .i_now       (r_in_now),
        .i_last_tap  (r_last_tap),
        .i_wake      (r_in_wake),
        .i_dims      (r_dims),
        .i_swipe_thr (r_swipe_thr),
        .i_tap_move  (r_tap_move),
        .i_debounce  (r_debounce),
        .o_event     (rel_event),
        .o_tap_taken (rel_tap)
    );

    // A release of a touch in progress reports the classified gesture.
    always_comb begin
        n_pressed = r_in_pressed;
        n_event   = (!r_in_pressed && r_pressed) ? rel_event : EV_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed  <= 1'b0;
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_last_x   <= '0;
            r_last_y   <= '0;
            r_last_tap <= '0;
        end else if (advance) begin
            r_pressed <= n_pressed;
            if (r_in_pressed) begin
                r_last_x <= px;
                r_last_y <= py;
                if (!r_pressed) begin
                    r_start_x <= px;
                    r_start_y <= py;
                end
            end else if (r_pressed && rel_tap) begin
                r_last_tap <= r_in_now;
            end
        end
    end

    // Result register and skid stage.
    logic   r_out_valid;
    t_event r_out_event;
    logic   r_out_active;
    t_event r_skid_event;
    logic   r_skid_active;
    logic   out_take;

    assign out_take = r_out_valid && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_take) begin
                if (r_skid_valid) begin
                    r_out_event  <= r_skid_event;
                    r_out_active <= r_skid_active;
                    r_skid_valid <= 1'b0;
                end else if (advance) begin
                    r_out_event  <= n_event;
                    r_out_active <= n_pressed;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (advance) begin
                if (!r_out_valid) begin
                    r_out_valid  <= 1'b1;
                    r_out_event  <= n_event;
                    r_out_active <= n_pressed;
                end else begin
                    r_skid_valid  <= 1'b1;
                    r_skid_event  <= n_event;
                    r_skid_active <= n_pressed;
                end
            end
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.gesture_event = r_out_event;
    assign o_result.touch_active  = r_out_active;

    // The skid stage only fills behind a waiting result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds an item with the result register empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !o_result.ready))
        else $error("skid stage filled while the result was taken");

    // A pressed sample always leaves the touch in progress.
    a_press_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_pressed) |=> r_pressed)
        else $error("press state not set by a pressed sample");

    // Gestures are reported only on the release of a touch in progress.
    a_event_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (n_event != EV_NONE)) |-> (r_pressed && !r_in_pressed))
        else $error("gesture reported outside a release");

endmodule

// File: bench/tb_touch_gesture_classifier.sv
// Testbench for the touch gesture classifier: drives poll samples and register
// writes, predicts each result (own model or directed script) and compares them in order.
// Depends on tgc_pkg, the channel interfaces in tgc_if and the RTL top level.
module tb_touch_gesture_classifier;
    timeunit 1ns;
    timeprecision 1ps;
    import tgc_pkg::*;

    localparam int PIXEL_MAX   = (1 << RAW_BITS) - 1;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 143;
    localparam int N_SETUPS    = 10;
    localparam int SHOWN_ERRS  = 10;

    // Register indexes beyond the last register; writes to them change nothing.
    localparam logic [CIDX_BITS-1:0] IDX_SPARE_A = 3'd6;
    localparam logic [CIDX_BITS-1:0] IDX_SPARE_B = 3'd7;

    typedef struct packed {
        logic [FC_BITS-1:0]  fingers;
        logic [RAW_BITS-1:0] raw_x;
        logic [RAW_BITS-1:0] raw_y;
        logic [47:0]         stamp_us;
        logic                wake;
    } t_touch_smp;

    typedef struct packed {
        t_event ev;
        logic   active;
    } t_gesture_res;

    typedef struct {
        t_touch_smp   smp;
        logic         typed;
        t_gesture_res want;
    } t_script_row;

    typedef struct {
        int unsigned w;
        int unsigned h;
        t_rot        rot;
        int unsigned swipe;
        int unsigned slop;
        int unsigned gap;
    } t_setup;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic calm_run;

    tgc_sample_if #(.TIME_BITS(48)) smp_if ();
    tgc_result_if                   res_if ();
    tgc_cfg_if                      cfg_if ();

    touch_gesture_classifier #(
        .COORD_BITS (12),
        .TIME_BITS  (48)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Register copies and press tracking of the prediction.
    logic [DIM_BITS-1:0] disp_w;
    logic [DIM_BITS-1:0] disp_h;
    t_rot                panel_rot;
    logic [THR_BITS-1:0] swipe_min;
    logic [THR_BITS-1:0] tap_slop;
    logic [DEB_BITS-1:0] tap_gap_us;
    logic                touch_down;
    logic [RAW_BITS-1:0] origin_x, origin_y, recent_x, recent_y;
    logic [47:0]         last_tap_us;

    t_gesture_res expected_gestures[$];
    int           n_items, n_results, n_mismatch, n_setups, stall_cycles;
    int           ev_tally[8];
    logic [47:0]  clock_us;

    // Directed samples: reset behavior, coordinate and time extremes, both swipe
    // directions, every tap zone, tap debounce and the wrap of the time counter.
    t_script_row gesture_script[26] = '{
        '{'{4'd0,  12'hFFF, 12'hFFF, 48'd0,       1'b1}, 1'b1, '{EV_NONE, 1'b0}},
        '{'{4'd15, 12'd0,   12'd0,   48'd1000,    1'b0}, 1'b1, '{EV_NONE, 1'b1}},
        '{'{4'd1,  12'hFFF, 12'hFFF, 48'd1500,    1'b1}, 1'b1, '{EV_NONE, 1'b1}},
        '{'{4'd0,  12'd0,   12'd0,   48'd2000,    1'b0}, 1'b1, '{EV_NONE, 1'b0}},
        '{'{4'd2,  12'd300, 12'd180, 48'd3000,    1'b0}, 1'b0, '{EV_NONE, 1'b0}},
        '{'{4'd3,  12'd100, 12'd190, 48'd4000,    1'b1}, 1'b0, '{EV_NONE, 1'b0}},
        '{'{4'd0,  12'd0,   12'd0,   48'd5000,    1'b0}, 1'b1, '{EV_SWIPE_NEXT, 1'b0}},
        '{'{4'd4,  12'd50,  12'd100, 48'd6000,    1'b0}, 1'b0, '{EV_NONE, 1'b0}},
        '{'{4'd8,  12'd250, 12'd100, 48'd7000,    1'b0}, 1'b0, '{EV_NONE, 1'b0}},
        '{'{4'd0,  12'hFFF, 12'd0,   48'd8000,    1'b0}, 1'b1, '{EV_SWIPE_PREV, 1'b0}},
        '{'{4'd1,  12'd20,  12'd340, 48'd299000,  1'b0}, 1'b0, '{EV_NONE, 1'b0}},
        '{'{4'd0,  12'd0,   12'd0,   48'd300000,  1'b0}, 1'b1, '{EV_VOL_DOWN, 1'b0}},
        '{'{4'd1,  12'd300, 12'd340, 48'd399000,  1'b0}, 1'b0, '{EV_NONE, 1'b0}},
        '{'{4'd0,  12'd0,   12'd0,   48'd400000,  1'b0}, 1'b0, '{EV_NONE, 1'b0}},
        '{'{4'd1,  12'd300, 12'd340, 48'd599000,  1'b0}, 1'b0, '{EV_NONE, 1'b0}},
        '{'{4'd0,  12'd0,   12'd0,   48'd600000,  1'b0}, 1'b1, '{EV_VOL_UP, 1'b0}},
        '{'{4'd1,  12'd180, 12'd340, 48'd899000,  1'b0}, 1'b0, '{EV_NONE, 1'b0}},
        '{'{4'd0,  12'd0,   12'd0,   48'd900000,  1'b0}, 1'b1, '{EV_MUTE, 1'b0}},
        '{'{4'd1,  12'd300, 12'd10,  48'd1199000, 1'b0}, 1'b0, '{EV_NONE, 1'b0}},
        '{'{4'd0,  12'd0,   12'd0,   48'd1200000, 1'b0}, 1'b1, '{EV_MUTE, 1'b0}},
        '{'{4'd1,  12'd180, 12'd180, 48'd1500000, 1'b0}, 1'b0, '{EV_NONE, 1'b0}},
        '{'{4'd0,  12'd0,   12'd0,   48'hFFFF_FFFF_FFFF, 1'b1}, 1'b1, '{EV_WAKE, 1'b0}},
        '{'{4'd1,  12'd180, 12'd180, 48'd50000,   1'b0}, 1'b0, '{EV_NONE, 1'b0}},
        '{'{4'd0,  12'd0,   12'd0,   48'd100000,  1'b1}, 1'b0, '{EV_NONE, 1'b0}},
        '{'{4'd1,  12'd180, 12'd180, 48'd200000,  1'b0}, 1'b0, '{EV_NONE, 1'b0}},
        '{'{4'd0,  12'd0,   12'd0,   48'd300000,  1'b1}, 1'b1, '{EV_WAKE, 1'b0}}
    };

    // Limit a coordinate to 0..hi, with hi never above the coordinate range.
    function automatic logic [RAW_BITS-1:0] clip_coord(input int v, input int hi);
        if (hi > PIXEL_MAX) hi = PIXEL_MAX;
        if (v > hi) v = hi;
        if (v < 0) v = 0;
        return RAW_BITS'(v);
    endfunction

    // Action of an accepted tap, found from where the touch began.
    function automatic t_event tap_zone_action(input int x, input int y, input logic wake,
                                               input int w, input int h);
        if (wake) return EV_WAKE;
        if (y <= MUTE_ZONE_Y && x >= w - MUTE_ZONE_W) return EV_MUTE;
        if (y < h - BOTTOM_ZONE_H) return EV_NONE;
        if (x < w / 3) return EV_VOL_DOWN;
        if (x >= (w * 2) / 3) return EV_VOL_UP;
        return EV_MUTE;
    endfunction

    // Advance the press tracking by one sample and return its result.
    function automatic t_gesture_res classify_sample(input t_touch_smp s);
        t_gesture_res r;
        int w, h, mx, my, px, py, rx, ry, dx, dy, ax, ay;
        logic [47:0] since;
        r.ev = EV_NONE;
        w = (disp_w == '0) ? 1 : disp_w;
        h = (disp_h == '0) ? 1 : disp_h;
        mx = w - 1;
        my = h - 1;
        rx = s.raw_x;
        ry = s.raw_y;
        if ((s.fingers & FINGER_MASK) == '0) begin
            if (touch_down) begin
                dx = recent_x;
                dx -= origin_x;
                dy = recent_y;
                dy -= origin_y;
                ax = (dx < 0) ? -dx : dx;
                ay = (dy < 0) ? -dy : dy;
                since = s.stamp_us - last_tap_us;
                if (ax >= swipe_min && ax > ay * 2) begin
                    r.ev = (dx < 0) ? EV_SWIPE_NEXT : EV_SWIPE_PREV;
                end else if (ax <= tap_slop && ay <= tap_slop && since >= tap_gap_us) begin
                    last_tap_us = s.stamp_us;
                    r.ev = tap_zone_action(origin_x, origin_y, s.wake, w, h);
                end
            end
            touch_down = 1'b0;
        end else begin
            case (panel_rot)
                ROT_90: begin
                    px = ry;
                    py = mx - rx;
                end
                ROT_180: begin
                    px = mx - rx;
                    py = my - ry;
                end
                ROT_270: begin
                    px = my - ry;
                    py = rx;
                end
                default: begin
                    px = rx;
                    py = ry;
                end
            endcase
            recent_x = clip_coord(px, mx);
            recent_y = clip_coord(py, my);
            if (!touch_down) begin
                touch_down = 1'b1;
                origin_x = recent_x;
                origin_y = recent_y;
            end
        end
        r.active = touch_down;
        return r;
    endfunction

    // Present one sample, with random idle cycles ahead of it, and record its result.
    task automatic offer_sample(input t_touch_smp s, input logic typed,
                                input t_gesture_res want);
        t_gesture_res r;
        while (!calm_run && $urandom_range(99) < 20) begin
            smp_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_if.valid        <= 1'b1;
        smp_if.point_count  <= s.fingers;
        smp_if.raw_x        <= s.raw_x;
        smp_if.raw_y        <= s.raw_y;
        smp_if.now_time     <= s.stamp_us;
        smp_if.wake_mode    <= s.wake;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        r = classify_sample(s);
        expected_gestures.push_back(typed ? want : r);
        n_items++;
    endtask

    // Write one register; the caller lowers valid after the last write of a batch.
    task automatic write_reg(input logic [CIDX_BITS-1:0] idx,
                             input logic [CDATA_BITS-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (t_cfg_idx'(idx))
            CFG_WIDTH:        disp_w     = val[DIM_BITS-1:0];
            CFG_HEIGHT:       disp_h     = val[DIM_BITS-1:0];
            CFG_ROTATION:     panel_rot  = t_rot'(val[ROT_BITS-1:0]);
            CFG_SWIPE_THR:    swipe_min  = val[THR_BITS-1:0];
            CFG_TAP_MOVE:     tap_slop   = val[THR_BITS-1:0];
            CFG_TAP_DEBOUNCE: tap_gap_us = val[DEB_BITS-1:0];
            default: ;
        endcase
    endtask

    // Wait until every predicted result has come back and the pipeline is empty.
    task automatic drain_results();
        smp_if.valid <= 1'b0;
        while (expected_gestures.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_setup(input t_setup p);
        drain_results();
        write_reg(IDX_SPARE_A, CDATA_BITS'($urandom));
        write_reg(IDX_SPARE_B, CDATA_BITS'($urandom));
        write_reg(CFG_WIDTH, CDATA_BITS'(p.w));
        write_reg(CFG_HEIGHT, CDATA_BITS'(p.h));
        write_reg(CFG_ROTATION, CDATA_BITS'(p.rot));
        write_reg(CFG_SWIPE_THR, CDATA_BITS'(p.swipe));
        write_reg(CFG_TAP_MOVE, CDATA_BITS'(p.slop));
        write_reg(CFG_TAP_DEBOUNCE, CDATA_BITS'(p.gap));
        cfg_if.valid <= 1'b0;
        n_setups++;
    endtask

    // One random touch: mostly taps and swipes, some wild moves, stray releases
    // and touches whose release never comes.
    task automatic play_gesture();
        t_touch_smp s;
        int kind, lim, bx, by, ox, oy, m, travel, perp, n;
        kind = $urandom_range(99);
        lim = (disp_w > disp_h) ? disp_w : disp_h;
        if (lim < 2 || lim > PIXEL_MAX + 1 || $urandom_range(9) == 0) lim = PIXEL_MAX + 1;
        bx = $urandom_range(lim - 1);
        by = $urandom_range(lim - 1);
        ox = 0;
        oy = 0;
        if ($urandom_range(49) == 0) clock_us = 48'({$urandom, $urandom});
        if (kind >= 90) begin
            clock_us += $urandom_range(1, 20000);
            s = '{4'd0, RAW_BITS'($urandom), RAW_BITS'($urandom), clock_us,
                  1'($urandom)};
            offer_sample(s, 1'b0, '0);
            return;
        end
        if (kind < 40) begin
            m = (tap_slop > 40) ? 40 : tap_slop;
            ox = $urandom_range(2 * m);
            ox -= m;
            oy = $urandom_range(2 * m);
            oy -= m;
        end else if (kind < 75) begin
            travel = swipe_min + $urandom_range(150);
            travel -= 5;
            if (travel < 0) travel = 0;
            perp = $urandom_range(travel / 2 + 3);
            if ($urandom_range(1)) perp = -perp;
            if ($urandom_range(1)) travel = -travel;
            if (panel_rot == ROT_90 || panel_rot == ROT_270) begin
                ox = perp;
                oy = travel;
            end else begin
                ox = travel;
                oy = perp;
            end
        end else begin
            ox = $urandom_range(PIXEL_MAX);
            ox -= bx;
            oy = $urandom_range(PIXEL_MAX);
            oy -= by;
        end
        n = $urandom_range(1, 4);
        for (int k = 0; k <= n; k++) begin
            clock_us += $urandom_range(1, 20000);
            s.fingers  = FC_BITS'($urandom_range(1, 15));
            s.raw_x    = clip_coord(bx + ox * k / n, PIXEL_MAX);
            s.raw_y    = clip_coord(by + oy * k / n, PIXEL_MAX);
            s.stamp_us = clock_us;
            s.wake     = 1'($urandom);
            offer_sample(s, 1'b0, '0);
        end
        if ($urandom_range(19) == 0) return;
        clock_us += $urandom_range(2 * tap_gap_us + 100);
        s = '{4'd0, RAW_BITS'($urandom), RAW_BITS'($urandom), clock_us,
              logic'($urandom_range(3) == 0)};
        offer_sample(s, 1'b0, '0);
    endtask

    // Result side: random stalls, except during the calm stretch.
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_if.ready <= calm_run || ($urandom_range(99) >= 20);
        end
    end

    // Compare each result with the oldest prediction and watch for a hang.
    always @(posedge i_clk) begin
        t_gesture_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            n_results++;
            ev_tally[res_if.gesture_event]++;
            if (expected_gestures.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= SHOWN_ERRS)
                    $display("Unexpected result: event %0d active %0b, nothing pending",
                             res_if.gesture_event, res_if.touch_active);
            end else begin
                want = expected_gestures.pop_front();
                if (res_if.gesture_event !== want.ev || res_if.touch_active !== want.active)
                begin
                    n_mismatch++;
                    if (n_mismatch <= SHOWN_ERRS)
                        $display("Result %0d: expected event %0d active %0b, got %0d %0b",
                                 n_results, want.ev, want.active,
                                 res_if.gesture_event, res_if.touch_active);
                end
            end
        end
        if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Main sequence: reset, directed script, then random touches under each setup.
    initial begin
        t_setup plan[N_SETUPS];
        int     phase_start;
        i_rst_n             <= 1'b0;
        calm_run            <= 1'b0;
        smp_if.valid        <= 1'b0;
        smp_if.point_count  <= '0;
        smp_if.raw_x        <= '0;
        smp_if.raw_y        <= '0;
        smp_if.now_time     <= '0;
        smp_if.wake_mode    <= 1'b0;
        cfg_if.valid        <= 1'b0;
        cfg_if.index        <= '0;
        cfg_if.data         <= '0;
        stall_cycles        <= 0;
        n_items     = 0;
        n_results   = 0;
        n_mismatch  = 0;
        n_setups    = 0;
        disp_w      = RST_WIDTH;
        disp_h      = RST_HEIGHT;
        panel_rot   = ROT_0;
        swipe_min   = RST_SWIPE;
        tap_slop    = RST_TAP_MOVE;
        tap_gap_us  = RST_DEBOUNCE;
        touch_down  = 1'b0;
        origin_x    = '0;
        origin_y    = '0;
        recent_x    = '0;
        recent_y    = '0;
        last_tap_us = '0;
        clock_us    = 48'd1000000;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (gesture_script[i])
            offer_sample(gesture_script[i].smp, gesture_script[i].typed,
                         gesture_script[i].want);

        // Fixed setups cover the register extremes; the rest are random.
        plan[0] = '{360, 360, ROT_90, 80, 30, 1000};
        plan[1] = '{4096, 4096, ROT_180, 0, 0, 0};
        plan[2] = '{1, 1, ROT_270, 4095, 4095, 16777215};
        plan[3] = '{0, 0, ROT_0, 50, 20, 5000};
        plan[4] = '{8191, 8191, ROT_0, 120, 25, 100000};
        plan[5] = '{240, 480, ROT_90, 60, 15, 250000};
        for (int i = 6; i < N_SETUPS; i++) begin
            plan[i].w     = $urandom_range(1, 4096);
            plan[i].h     = $urandom_range(1, 4096);
            plan[i].rot   = t_rot'($urandom_range(3));
            plan[i].swipe = ($urandom_range(3) == 0) ? $urandom_range(4095)
                                                     : $urandom_range(20, 300);
            plan[i].slop  = ($urandom_range(3) == 0) ? $urandom_range(4095)
                                                     : $urandom_range(60);
            plan[i].gap   = ($urandom_range(3) == 0) ? $urandom_range(16777215)
                                                     : $urandom_range(2000000);
        end

        for (int i = 0; i < N_SETUPS; i++) begin
            apply_setup(plan[i]);
            // The full-size setup runs with no idle cycles on either side.
            calm_run <= (i == 1);
            phase_start = n_items;
            while (n_items - phase_start < PHASE_ITEMS) play_gesture();
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        $display("Run covered %0d samples under %0d register setups and %0d results.",
                 n_items, n_setups, n_results);
        $display("Swipes reported: %0d, tap actions reported: %0d, mismatches: %0d.",
                 ev_tally[EV_SWIPE_NEXT] + ev_tally[EV_SWIPE_PREV],
                 ev_tally[EV_WAKE] + ev_tally[EV_VOL_DOWN] + ev_tally[EV_VOL_UP] +
                 ev_tally[EV_MUTE], n_mismatch);
        if (n_mismatch == 0 && expected_gestures.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/tgc_pkg.sv
hdl/tgc_if.sv
hdl/tgc_rotate.sv
hdl/tgc_release.sv
hdl/touch_gesture_classifier.sv
bench/tb_touch_gesture_classifier.sv
